@@ rtl/kcr_pkg.sv @@
// Package for the key chord remapper: sizes, result codes and shared types.
// No dependencies.
package kcr_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_HELD      = 8;
    localparam int TRIGGER_KEYS  = 4;
    localparam int OUTPUT_KEYS   = 4;

    localparam logic [1:0] EV_KEY    = 2'd0;
    localparam logic [1:0] EV_SYN    = 2'd1;
    localparam logic [1:0] RUN_CMD   = 2'd2;
    localparam logic [9:0] SYNC_CODE = 10'd0;

    localparam logic [1:0] EVK_RELEASE = 2'd0;
    localparam logic [1:0] EVK_PRESS   = 2'd1;
    localparam logic [1:0] EVK_REPEAT  = 2'd2;

    localparam logic [1:0] CFG_SINK  = 2'd0;
    localparam logic [1:0] CFG_SYNC  = 2'd1;
    localparam logic [1:0] CFG_REMAP = 2'd2;

    // Item handed from the front to the back through the queue.
    typedef struct packed {
        logic        operation;
        logic [1:0]  event_kind;
        logic [9:0]  key_code;
        logic [3:0]  entry_index;
        logic        entry_valid;
        logic [2:0]  trigger_length;
        logic [39:0] trigger_keys;
        logic        map_present;
        logic [2:0]  output_length;
        logic [39:0] output_keys;
        logic        exec_present;
        logic [7:0]  command_tag_in;
    } item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [1:0] out_event_kind;
        logic [9:0] out_key_code;
        logic [7:0] command_tag;
        logic       last_of_run;
    } result_t;
endpackage

@@ rtl/kcr_front.sv @@
// Front of the key chord remapper: accepts input words, drops unusable ones
// and queues the rest. Depends on kcr_pkg.
module kcr_front #(
    parameter int TABLE_ENTRIES = kcr_pkg::TABLE_ENTRIES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kcr_pkg::item_t  in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output kcr_pkg::item_t  q_item
);
    localparam int DEPTH = 2;

    kcr_pkg::item_t mem_reg [DEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       keep, push, pop;

    // Event kind three and out-of-range loads cause nothing, so they never enter the queue.
    always_comb
    begin
        if (in_item.operation)
            keep = ({28'd0, in_item.entry_index} < 32'(TABLE_ENTRIES));
        else
            keep = (in_item.event_kind != 2'd3);
    end

    assign in_ready = (cnt_reg != 2'(DEPTH));
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end
endmodule

@@ rtl/kcr_back.sv @@
// Back of the key chord remapper: table, held list, scan and emit sequencer.
// Depends on kcr_pkg.
module kcr_back #(
    parameter int TABLE_ENTRIES = kcr_pkg::TABLE_ENTRIES,
    parameter int MAX_HELD      = kcr_pkg::MAX_HELD,
    parameter int TRIGGER_KEYS  = kcr_pkg::TRIGGER_KEYS,
    parameter int OUTPUT_KEYS   = kcr_pkg::OUTPUT_KEYS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  kcr_pkg::item_t   q_item,
    input  logic             sink_on,
    input  logic             sync_after_each,
    input  logic             remap_enabled,
    output logic             out_valid,
    input  logic             out_ready,
    output kcr_pkg::result_t out_res
);
    localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int HW  = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int CW  = $clog2(MAX_HELD + 1);
    localparam int ECW = $clog2(TABLE_ENTRIES + 1);
    localparam int NT  = (TRIGGER_KEYS < 4) ? TRIGGER_KEYS : 4;
    localparam int NO  = (OUTPUT_KEYS < 4) ? OUTPUT_KEYS : 4;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SREAD = 4'd3;
    localparam logic [3:0] S_SCHK  = 4'd4;
    localparam logic [3:0] S_EMIT  = 4'd5;
    localparam logic [3:0] S_SYNC  = 4'd6;
    localparam logic [3:0] S_CMD   = 4'd7;
    localparam logic [3:0] S_CUT   = 4'd8;
    localparam logic [3:0] S_NEXT  = 4'd9;
    localparam logic [3:0] S_FLUSH = 4'd10;

    // Phases of one key event.
    localparam logic [2:0] P_PRE  = 3'd0; // press: release earlier multi-key output
    localparam logic [2:0] P_EXEC = 3'd1;
    localparam logic [2:0] P_MAP  = 3'd2;
    localparam logic [2:0] P_DONE = 3'd3;

    // Table entry: len, trig keys, map, olen, out keys, exec, tag; used bits live in used_reg.
    typedef struct packed {
        logic [2:0]  tlen;
        logic [39:0] tkeys;
        logic        map_present;
        logic [2:0]  olen;
        logic [39:0] okeys;
        logic        exec_present;
        logic [7:0]  tag;
    } entry_t;

    entry_t     tbl_mem [TABLE_ENTRIES];
    entry_t     rd_reg;
    logic [TABLE_ENTRIES-1:0] used_reg, used_next;
    logic [9:0] held_reg [MAX_HELD];
    logic [CW-1:0] hcnt_reg, hcnt_next;

    logic [3:0]  st_reg, st_next;
    logic [2:0]  ph_reg, ph_next;
    kcr_pkg::item_t it_reg;
    logic [ECW-1:0] sidx_reg, sidx_next;
    logic        swant_reg, swant_next; // 1 exec lookup
    logic        hit_reg, hit_next;
    entry_t      act_reg, act_next;
    // emission plan
    logic [2:0]  ecnt_reg, ecnt_next;   // keys left to emit
    logic [2:0]  epos_reg, epos_next;   // next key position
    logic        edir_reg, edir_next;   // 1 descending
    logic [1:0]  eev_reg, eev_next;
    logic        eraw_reg, eraw_next;   // emit input key itself
    logic [HW-1:0] cpos_reg, cpos_next;
    logic        held_wr;
    logic [9:0]  emit_code;

    kcr_pkg::result_t res_reg, res_next;
    logic        ov_reg, ov_next;
    // The newest word waits here until the next word or the end of the item shows
    // whether it is the last one.
    kcr_pkg::result_t hold_reg, hold_next;
    logic        hv_reg, hv_next;
    logic        slot_free;
    logic        take_ok;
    logic        trig_ok;

    assign slot_free = !ov_reg || out_ready;
    assign take_ok   = !hv_reg || slot_free;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign q_ready   = (st_reg == S_IDLE);

    // Trigger compare against the held list, one key per lane.
    always_comb
    begin
        trig_ok = ({29'd0, rd_reg.tlen} != 32'd0) && ({29'd0, rd_reg.tlen} <= 32'(NT))
                  && ({28'd0, 1'b0, rd_reg.tlen} == 32'(hcnt_reg));
        for (int i = 0; i < NT; i++)
        begin
            if (i < MAX_HELD && 3'(i) < rd_reg.tlen
                && rd_reg.tkeys[i*10 +: 10] != held_reg[i])
                trig_ok = 1'b0;
        end
        if (!used_reg[sidx_reg[EW-1:0]])
            trig_ok = 1'b0;
        if (swant_reg ? !rd_reg.exec_present : !rd_reg.map_present)
            trig_ok = 1'b0;
    end

    always_comb
    begin
        emit_code = eraw_reg ? it_reg.key_code : act_reg.okeys[epos_reg[1:0]*10 +: 10];
    end

    always_comb
    begin
        st_next    = st_reg;
        ph_next    = ph_reg;
        sidx_next  = sidx_reg;
        swant_next = swant_reg;
        hit_next   = hit_reg;
        act_next   = act_reg;
        ecnt_next  = ecnt_reg;
        epos_next  = epos_reg;
        edir_next  = edir_reg;
        eev_next   = eev_reg;
        eraw_next  = eraw_reg;
        cpos_next  = cpos_reg;
        hcnt_next  = hcnt_reg;
        used_next  = used_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && !out_ready;
        hold_next  = hold_reg;
        hv_next    = hv_reg;
        held_wr    = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.operation)
                        st_next = S_LOAD;
                    else
                    begin
                        ph_next    = (q_item.event_kind == kcr_pkg::EVK_PRESS) ? P_PRE
                                   : (q_item.event_kind == kcr_pkg::EVK_REPEAT) ? P_EXEC
                                   : P_MAP;
                        swant_next = (q_item.event_kind == kcr_pkg::EVK_REPEAT);
                        sidx_next  = '0;
                        hit_next   = 1'b0;
                        st_next    = S_SCAN;
                    end
                end
            end
            S_LOAD:
            begin
                used_next[it_reg.entry_index[EW-1:0]] = it_reg.entry_valid;
                st_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (sidx_reg == ECW'(TABLE_ENTRIES))
                    st_next = S_SCHK;
                else
                    st_next = S_SREAD;
            end
            S_SREAD:
            begin
                // rd_reg holds entry sidx; check it.
                if (trig_ok)
                begin
                    hit_next = 1'b1;
                    act_next = rd_reg;
                    st_next  = S_SCHK;
                end
                else
                begin
                    sidx_next = sidx_reg + 1'b1;
                    st_next   = S_SCAN;
                end
            end
            S_SCHK:
            begin
                ecnt_next = 3'd0;
                eraw_next = 1'b0;
                case (ph_reg)
                    P_PRE:
                    begin
                        if (hit_reg && act_reg.olen > 3'd1)
                        begin
                            ecnt_next = act_reg.olen;
                            epos_next = act_reg.olen - 3'd1;
                            edir_next = 1'b1;
                            eev_next  = kcr_pkg::EVK_RELEASE;
                        end
                        st_next = S_NEXT;
                    end
                    P_EXEC:
                        st_next = hit_reg ? S_CMD : S_NEXT;
                    default:
                    begin
                        if (hit_reg)
                        begin
                            if (act_reg.olen == 3'd1)
                            begin
                                ecnt_next = 3'd1;
                                epos_next = 3'd0;
                                eev_next  = it_reg.event_kind;
                            end
                            else if (act_reg.olen > 3'd1)
                            begin
                                eev_next = it_reg.event_kind;
                                if (it_reg.event_kind == kcr_pkg::EVK_RELEASE)
                                begin
                                    ecnt_next = act_reg.olen;
                                    epos_next = act_reg.olen - 3'd1;
                                    edir_next = 1'b1;
                                end
                                else if (it_reg.event_kind == kcr_pkg::EVK_PRESS)
                                begin
                                    ecnt_next = act_reg.olen;
                                    epos_next = 3'd0;
                                    edir_next = 1'b0;
                                end
                                else
                                begin
                                    ecnt_next = 3'd1;
                                    epos_next = act_reg.olen - 3'd1;
                                end
                            end
                        end
                        else if (remap_enabled && !sink_on)
                        begin
                            ecnt_next = 3'd1;
                            eraw_next = 1'b1;
                            eev_next  = it_reg.event_kind;
                        end
                        st_next = S_NEXT;
                    end
                endcase
                if (st_next == S_NEXT && ecnt_next != 3'd0)
                    st_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (take_ok)
                begin
                    if (hv_reg)
                    begin
                        ov_next  = 1'b1;
                        res_next = hold_reg;
                    end
                    hv_next   = 1'b1;
                    hold_next = '{kcr_pkg::EV_KEY, eev_reg, emit_code, 8'd0, 1'b0};
                    ecnt_next = ecnt_reg - 3'd1;
                    epos_next = edir_reg ? epos_reg - 3'd1 : epos_reg + 3'd1;
                    if (sync_after_each)
                        st_next = S_SYNC;
                    else if (ecnt_reg == 3'd1)
                        st_next = S_NEXT;
                end
            end
            S_SYNC:
            begin
                if (take_ok)
                begin
                    if (hv_reg)
                    begin
                        ov_next  = 1'b1;
                        res_next = hold_reg;
                    end
                    hv_next   = 1'b1;
                    hold_next = '{kcr_pkg::EV_SYN, 2'd0, kcr_pkg::SYNC_CODE, 8'd0, 1'b0};
                    st_next   = (ecnt_reg == 3'd0) ? S_NEXT : S_EMIT;
                end
            end
            S_CMD:
            begin
                if (take_ok)
                begin
                    if (hv_reg)
                    begin
                        ov_next  = 1'b1;
                        res_next = hold_reg;
                    end
                    hv_next   = 1'b1;
                    hold_next = '{kcr_pkg::RUN_CMD, 2'd0, 10'd0, act_reg.tag, 1'b0};
                    st_next   = S_NEXT;
                end
            end
            S_NEXT:
            begin
                sidx_next = '0;
                hit_next  = 1'b0;
                case (ph_reg)
                    P_PRE:
                    begin
                        if (hcnt_reg < CW'(MAX_HELD))
                        begin
                            held_wr   = 1'b1;
                            hcnt_next = hcnt_reg + 1'b1;
                        end
                        ph_next    = P_EXEC;
                        swant_next = 1'b1;
                        st_next    = S_SCAN;
                    end
                    P_EXEC:
                    begin
                        ph_next    = P_MAP;
                        swant_next = 1'b0;
                        st_next    = S_SCAN;
                    end
                    P_MAP:
                    begin
                        cpos_next = '0;
                        ph_next   = P_DONE;
                        st_next   = (it_reg.event_kind == kcr_pkg::EVK_RELEASE) ? S_CUT
                                                                                : S_FLUSH;
                    end
                    default:
                        st_next = S_IDLE;
                endcase
            end
            S_CUT:
            begin
                // Walk the held list one key a cycle, cut at the first match.
                if ({1'b0, cpos_reg} >= (HW+1)'(hcnt_reg))
                    st_next = S_FLUSH;
                else if (held_reg[cpos_reg] == it_reg.key_code)
                begin
                    hcnt_next = CW'(cpos_reg);
                    st_next   = S_FLUSH;
                end
                else if (32'(cpos_reg) == MAX_HELD - 1)
                    st_next = S_FLUSH;
                else
                    cpos_next = cpos_reg + 1'b1;
            end
            S_FLUSH:
            begin
                // The word still held is the last one of this item.
                if (!hv_reg)
                    st_next = S_IDLE;
                else if (slot_free)
                begin
                    ov_next              = 1'b1;
                    res_next             = hold_reg;
                    res_next.last_of_run = 1'b1;
                    hv_next              = 1'b0;
                    st_next              = S_IDLE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            ph_reg    <= P_DONE;
            used_reg  <= '0;
            hcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            hv_reg    <= 1'b0;
            sidx_reg  <= '0;
            swant_reg <= 1'b0;
            hit_reg   <= 1'b0;
            ecnt_reg  <= 3'd0;
        end
        else
        begin
            st_reg    <= st_next;
            ph_reg    <= ph_next;
            used_reg  <= used_next;
            hcnt_reg  <= hcnt_next;
            ov_reg    <= ov_next;
            hv_reg    <= hv_next;
            sidx_reg  <= sidx_next;
            swant_reg <= swant_next;
            hit_reg   <= hit_next;
            ecnt_reg  <= ecnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        epos_reg <= epos_next;
        edir_reg <= edir_next;
        eev_reg  <= eev_next;
        eraw_reg <= eraw_next;
        cpos_reg <= cpos_next;
        res_reg  <= res_next;
        hold_reg <= hold_next;
        if (st_reg == S_IDLE && q_valid)
            it_reg <= q_item;
        if (held_wr)
            held_reg[hcnt_reg[HW-1:0]] <= it_reg.key_code;
        if (st_reg == S_LOAD)
            tbl_mem[it_reg.entry_index[EW-1:0]] <= '{
                it_reg.trigger_length, it_reg.trigger_keys, it_reg.map_present,
                (it_reg.output_length > 3'(NO)) ? 3'(NO) : it_reg.output_length,
                it_reg.output_keys, it_reg.exec_present, it_reg.command_tag_in};
        if (st_reg == S_SCAN && sidx_reg != ECW'(TABLE_ENTRIES))
            rd_reg <= tbl_mem[sidx_reg[EW-1:0]];
    end
endmodule

@@ rtl/key_chord_remapper_core.sv @@
// Top level of the key chord remapper: config registers, front and back.
// Depends on kcr_pkg, kcr_front and kcr_back.
//
//  channel  | handshake              | payload
//  in       | in_valid / in_ready    | operation .. command_tag_in
//  out      | out_valid / out_ready  | result_kind .. last_of_run
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// A key event leaves the queue when the back is idle; each lookup reads the table
// one entry at a time through its scan and read states. A press runs three lookups,
// a repeat two, a release one, and a press gives up to 17 words. Words pass a
// one-word hold stage, one a cycle while the output takes them; a release then
// walks the held list. A load holds the back in its load state. The two-word queue
// lets the front take words while the back works. Output stalls hold the sequencer
// in place. Reset empties the held list, clears the valid bits and sets sync on.
module key_chord_remapper_core #(
    parameter int TABLE_ENTRIES = kcr_pkg::TABLE_ENTRIES,
    parameter int MAX_HELD      = kcr_pkg::MAX_HELD,
    parameter int TRIGGER_KEYS  = kcr_pkg::TRIGGER_KEYS,
    parameter int OUTPUT_KEYS   = kcr_pkg::OUTPUT_KEYS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [1:0]  event_kind,
    input  logic [9:0]  key_code,
    input  logic [3:0]  entry_index,
    input  logic        entry_valid,
    input  logic [2:0]  trigger_length,
    input  logic [39:0] trigger_keys,
    input  logic        map_present,
    input  logic [2:0]  output_length,
    input  logic [39:0] output_keys,
    input  logic        exec_present,
    input  logic [7:0]  command_tag_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [1:0]  out_event_kind,
    output logic [9:0]  out_key_code,
    output logic [7:0]  command_tag,
    output logic        last_of_run,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);
    kcr_pkg::item_t   in_item, q_item;
    kcr_pkg::result_t res;
    logic q_valid, q_ready;
    logic sink_reg, sync_reg, remap_reg;

    assign in_item = '{operation, event_kind, key_code, entry_index, entry_valid,
                       trigger_length, trigger_keys, map_present, output_length,
                       output_keys, exec_present, command_tag_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_reg  <= 1'b0;
            sync_reg  <= 1'b1;
            remap_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kcr_pkg::CFG_SINK:  sink_reg  <= cfg_data;
                kcr_pkg::CFG_SYNC:  sync_reg  <= cfg_data;
                kcr_pkg::CFG_REMAP: remap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    kcr_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    kcr_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .MAX_HELD(MAX_HELD),
        .TRIGGER_KEYS(TRIGGER_KEYS), .OUTPUT_KEYS(OUTPUT_KEYS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .sink_on(sink_reg), .sync_after_each(sync_reg), .remap_enabled(remap_reg),
        .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
    );

    assign result_kind    = res.result_kind;
    assign out_event_kind = res.out_event_kind;
    assign out_key_code   = res.out_key_code;
    assign command_tag    = res.command_tag;
    assign last_of_run    = res.last_of_run;
endmodule

@@ rtl/kcr_checker.sv @@
// Port-level checker for the key chord remapper, bound to the top level.
// Depends on kcr_pkg.
module kcr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] result_kind,
    input logic [1:0] out_event_kind,
    input logic [9:0] out_key_code,
    input logic [7:0] command_tag,
    input logic       last_of_run
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key_code) && $stable(last_of_run))
        else $error("output word changed while stalled");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind != 2'd3)
        else $error("bad result kind");
    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == kcr_pkg::EV_SYN |-> out_key_code == kcr_pkg::SYNC_CODE
        && out_event_kind == 2'd0 && command_tag == 8'd0)
        else $error("sync word carries a payload");
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == kcr_pkg::RUN_CMD |-> out_key_code == 10'd0
        && out_event_kind == 2'd0)
        else $error("command word malformed");
endmodule

bind key_chord_remapper_core kcr_checker u_kcr_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .out_event_kind(out_event_kind),
    .out_key_code(out_key_code), .command_tag(command_tag), .last_of_run(last_of_run)
);

@@ verif/tb_key_chord_remapper_core.sv @@
// Self-checking testbench for key_chord_remapper_core: directed chords, then random chords,
// table loads and noise, with a scoreboard class that predicts every result word.
// Depends on kcr_pkg and the RTL of key_chord_remapper_core.
`timescale 1ns / 100ps

module tb_key_chord_remapper_core;

    localparam logic [1:0] EVK_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int MAX_RUN = 17;

    class chord_scoreboard;
        bit drop_unmapped;
        bit sync_each;
        bit remap_on;
        logic [9:0] held [kcr_pkg::MAX_HELD];
        int held_n;
        bit in_use [kcr_pkg::TABLE_ENTRIES];
        logic [2:0] trig_len [kcr_pkg::TABLE_ENTRIES];
        logic [39:0] trig_keys [kcr_pkg::TABLE_ENTRIES];
        bit map_p [kcr_pkg::TABLE_ENTRIES];
        int out_len [kcr_pkg::TABLE_ENTRIES];
        logic [39:0] out_keys [kcr_pkg::TABLE_ENTRIES];
        bit exec_p [kcr_pkg::TABLE_ENTRIES];
        logic [7:0] cmd_tag [kcr_pkg::TABLE_ENTRIES];
        kcr_pkg::result_t pending_results[$];
        kcr_pkg::result_t run_q[$];
        int errors;
        int checked;
        int key_items;
        int load_items;

        function new();
            drop_unmapped = 0;
            sync_each = 1;
            remap_on = 0;
            held_n = 0;
            foreach (in_use[i]) in_use[i] = 0;
            errors = 0;
            checked = 0;
            key_items = 0;
            load_items = 0;
        endfunction

        function void set_reg(logic [1:0] idx, bit v);
            case (idx)
                kcr_pkg::CFG_SINK:  drop_unmapped = v;
                kcr_pkg::CFG_SYNC:  sync_each = v;
                kcr_pkg::CFG_REMAP: remap_on = v;
                default: ;
            endcase
        endfunction

        function logic [9:0] key_at(logic [39:0] w, int i);
            return w[i*10 +: 10];
        endfunction

        // Lowest entry in use, with the wanted map or exec part, whose trigger equals the held list exactly.
        function int match_entry(bit want_exec);
            int e;
            int i;
            bit ok;
            for (e = 0; e < kcr_pkg::TABLE_ENTRIES; e++) begin
                if (!in_use[e]) continue;
                if (want_exec ? !exec_p[e] : !map_p[e]) continue;
                if (trig_len[e] == 0 || trig_len[e] > kcr_pkg::TRIGGER_KEYS
                    || trig_len[e] != held_n)
                    continue;
                ok = 1;
                for (i = 0; i < trig_len[e]; i++)
                    if (key_at(trig_keys[e], i) != held[i]) ok = 0;
                if (ok) return e;
            end
            return -1;
        endfunction

        function void add(logic [1:0] kind, logic [1:0] ev, logic [9:0] code, logic [7:0] t);
            kcr_pkg::result_t r;
            if (run_q.size() >= MAX_RUN) return;
            r.result_kind = kind;
            r.out_event_kind = ev;
            r.out_key_code = code;
            r.command_tag = t;
            r.last_of_run = 0;
            run_q = {run_q, r};
        endfunction

        function void add_key(logic [1:0] ev, logic [9:0] code);
            add(kcr_pkg::EV_KEY, ev, code, 8'd0);
            if (sync_each)
                add(kcr_pkg::EV_SYN, kcr_pkg::EVK_RELEASE, kcr_pkg::SYNC_CODE, 8'd0);
        endfunction

        function void note_accepted(kcr_pkg::item_t it);
            int e;
            int i;
            logic [1:0] ev;
            logic [9:0] code;
            run_q.delete();
            if (it.operation) begin
                load_items++;
                e = it.entry_index;
                in_use[e] = it.entry_valid;
                trig_len[e] = it.trigger_length;
                trig_keys[e] = it.trigger_keys;
                map_p[e] = it.map_present;
                out_len[e] = (it.output_length > kcr_pkg::OUTPUT_KEYS) ? kcr_pkg::OUTPUT_KEYS
                                                                       : it.output_length;
                out_keys[e] = it.output_keys;
                exec_p[e] = it.exec_present;
                cmd_tag[e] = it.command_tag_in;
                return;
            end
            ev = it.event_kind;
            code = it.key_code;
            if (ev == EVK_UNUSED) return;
            key_items++;
            if (ev == kcr_pkg::EVK_PRESS) begin
                // An added key first lifts a multi-key output of the old chord.
                e = match_entry(0);
                if (e >= 0 && out_len[e] > 1)
                    for (i = out_len[e] - 1; i >= 0; i--)
                        add_key(kcr_pkg::EVK_RELEASE, key_at(out_keys[e], i));
                if (held_n < kcr_pkg::MAX_HELD) begin
                    held[held_n] = code;
                    held_n++;
                end
            end
            if (ev == kcr_pkg::EVK_PRESS || ev == kcr_pkg::EVK_REPEAT) begin
                e = match_entry(1);
                if (e >= 0) add(kcr_pkg::RUN_CMD, kcr_pkg::EVK_RELEASE, 10'd0, cmd_tag[e]);
            end
            e = match_entry(0);
            if (e >= 0) begin
                if (out_len[e] == 1)
                    add_key(ev, key_at(out_keys[e], 0));
                else if (out_len[e] > 1) begin
                    if (ev == kcr_pkg::EVK_RELEASE)
                        for (i = out_len[e] - 1; i >= 0; i--)
                            add_key(kcr_pkg::EVK_RELEASE, key_at(out_keys[e], i));
                    else if (ev == kcr_pkg::EVK_PRESS)
                        for (i = 0; i < out_len[e]; i++)
                            add_key(kcr_pkg::EVK_PRESS, key_at(out_keys[e], i));
                    else
                        add_key(kcr_pkg::EVK_REPEAT, key_at(out_keys[e], out_len[e] - 1));
                end
            end else if (remap_on && !drop_unmapped)
                add_key(ev, code);
            if (ev == kcr_pkg::EVK_RELEASE)
                for (i = 0; i < held_n; i++)
                    if (held[i] == code) begin
                        held_n = i;
                        break;
                    end
            if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1;
            foreach (run_q[i]) pending_results = {pending_results, run_q[i]};
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(kcr_pkg::result_t got);
            kcr_pkg::result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("out_event_kind", want.out_event_kind, got.out_event_kind);
            compare_field("out_key_code", want.out_key_code, got.out_key_code);
            compare_field("command_tag", want.command_tag, got.command_tag);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [1:0]  event_kind;
    logic [9:0]  key_code;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [2:0]  trigger_length;
    logic [39:0] trigger_keys;
    logic        map_present;
    logic [2:0]  output_length;
    logic [39:0] output_keys;
    logic        exec_present;
    logic [7:0]  command_tag_in;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [1:0]  out_event_kind;
    logic [9:0]  out_key_code;
    logic [7:0]  command_tag;
    logic        last_of_run;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic        cfg_data;

    chord_scoreboard sb;
    bit tx_gaps;
    bit rx_stalls;
    int long_hold;
    int stall_left;
    logic [9:0] pool [8];

    key_chord_remapper_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .event_kind(event_kind), .key_code(key_code),
        .entry_index(entry_index), .entry_valid(entry_valid),
        .trigger_length(trigger_length), .trigger_keys(trigger_keys),
        .map_present(map_present), .output_length(output_length),
        .output_keys(output_keys), .exec_present(exec_present),
        .command_tag_in(command_tag_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .out_event_kind(out_event_kind),
        .out_key_code(out_key_code), .command_tag(command_tag),
        .last_of_run(last_of_run),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Output side: checks each word taken and stalls in random bursts.
    always @(posedge clk) begin
        kcr_pkg::result_t got;
        if (out_valid && out_ready) begin
            got.result_kind = result_kind;
            got.out_event_kind = out_event_kind;
            got.out_key_code = out_key_code;
            got.command_tag = command_tag;
            got.last_of_run = last_of_run;
            sb.check_result(got);
        end
        if (long_hold > 0) begin
            out_ready <= 0;
            long_hold--;
        end else if (stall_left > 0) begin
            out_ready <= 0;
            stall_left--;
        end else if (rx_stalls && $urandom_range(0, 99) < 20) begin
            out_ready <= 0;
            stall_left = $urandom_range(1, 9) - 1;
        end else
            out_ready <= 1;
    end

    function automatic logic [39:0] pack4(logic [9:0] a, logic [9:0] b, logic [9:0] c,
                                          logic [9:0] d);
        return {d, c, b, a};
    endfunction

    function automatic kcr_pkg::item_t random_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(kcr_pkg::item_t)-1:0];
    endfunction

    function automatic kcr_pkg::item_t key_item(logic [1:0] ev, logic [9:0] code);
        kcr_pkg::item_t it;
        it = random_item();
        it.operation = 0;
        it.event_kind = ev;
        it.key_code = code;
        return it;
    endfunction

    function automatic kcr_pkg::item_t load_item(int idx, bit valid, int tlen,
                                                 logic [39:0] tkeys, bit mp, int olen,
                                                 logic [39:0] okeys, bit ex,
                                                 logic [7:0] tag);
        kcr_pkg::item_t it;
        it = random_item();
        it.operation = 1;
        it.entry_index = 4'(idx);
        it.entry_valid = valid;
        it.trigger_length = 3'(tlen);
        it.trigger_keys = tkeys;
        it.map_present = mp;
        it.output_length = 3'(olen);
        it.output_keys = okeys;
        it.exec_present = ex;
        it.command_tag_in = tag;
        return it;
    endfunction

    task automatic send(kcr_pkg::item_t it);
        operation <= it.operation;
        event_kind <= it.event_kind;
        key_code <= it.key_code;
        entry_index <= it.entry_index;
        entry_valid <= it.entry_valid;
        trigger_length <= it.trigger_length;
        trigger_keys <= it.trigger_keys;
        map_present <= it.map_present;
        output_length <= it.output_length;
        output_keys <= it.output_keys;
        exec_present <= it.exec_present;
        command_tag_in <= it.command_tag_in;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_accepted(it);
        if (tx_gaps && $urandom_range(0, 99) < 25) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Waits for every expected word, then long enough for queued items that emit nothing.
    task automatic drain();
        in_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_config(bit sink, bit sync, bit remap);
        cfg_we <= 1;
        cfg_index <= kcr_pkg::CFG_SINK;
        cfg_data <= sink;
        @(posedge clk);
        sb.set_reg(kcr_pkg::CFG_SINK, sink);
        cfg_index <= kcr_pkg::CFG_SYNC;
        cfg_data <= sync;
        @(posedge clk);
        sb.set_reg(kcr_pkg::CFG_SYNC, sync);
        cfg_index <= kcr_pkg::CFG_REMAP;
        cfg_data <= remap;
        @(posedge clk);
        sb.set_reg(kcr_pkg::CFG_REMAP, remap);
        cfg_index <= CFG_UNUSED;
        cfg_data <= 1'($urandom_range(0, 1));
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [9:0] pick_key();
        return pool[$urandom_range(0, 7)];
    endfunction

    task automatic random_load();
        send(load_item($urandom_range(0, 15), $urandom_range(0, 99) < 85,
                       ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(0, 7),
                       ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom}) :
                           pack4(pick_key(), pick_key(), pick_key(), pick_key()),
                       $urandom_range(0, 99) < 75, $urandom_range(0, 7),
                       40'({$urandom, $urandom}), $urandom_range(0, 99) < 40,
                       8'($urandom)));
    endtask

    // Mostly well-formed chords over the key pool, some loads and raw noise.
    task automatic random_phase(int n);
        int count;
        int k;
        int i;
        int j;
        logic [9:0] chord [5];
        logic [9:0] t;
        count = 0;
        repeat (6) random_load();
        while (count < n) begin
            k = $urandom_range(0, 99);
            if (k < 10) begin
                random_load();
                count++;
            end else if (k < 20) begin
                send(key_item(2'($urandom_range(0, 3)), 10'($urandom)));
                count++;
            end else begin
                k = $urandom_range(1, 5);
                for (i = 0; i < k; i++) begin
                    chord[i] = pick_key();
                    send(key_item(kcr_pkg::EVK_PRESS, chord[i]));
                    count++;
                    if ($urandom_range(0, 2) == 0) begin
                        send(key_item(kcr_pkg::EVK_REPEAT, chord[i]));
                        count++;
                    end
                end
                for (i = k - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    t = chord[i];
                    chord[i] = chord[j];
                    chord[j] = t;
                end
                for (i = 0; i < k; i++) begin
                    send(key_item(kcr_pkg::EVK_RELEASE, chord[i]));
                    count++;
                end
            end
        end
    endtask

    initial begin
        logic [9:0] ka;
        logic [9:0] kb;
        logic [9:0] kc;
        logic [9:0] kd;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        operation = 0;
        event_kind = kcr_pkg::EVK_RELEASE;
        key_code = 0;
        entry_index = 0;
        entry_valid = 0;
        trigger_length = 0;
        trigger_keys = 0;
        map_present = 0;
        output_length = 0;
        output_keys = 0;
        exec_present = 0;
        command_tag_in = 0;
        cfg_we = 0;
        cfg_index = kcr_pkg::CFG_SINK;
        cfg_data = 0;
        tx_gaps = 1;
        rx_stalls = 1;
        long_hold = 0;
        stall_left = 0;
        ka = 10'd30;
        kb = 10'd48;
        kc = 10'd46;
        kd = 10'd32;
        pool = '{ka, kb, kc, kd, 10'd29, 10'd56, 10'd1023, 10'd0};
        repeat (6) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Directed chords under the reset setting of sync, with forwarding on.
        write_config(0, 1, 1);
        send(load_item(0, 1, 1, pack4(ka, 10'd0, 10'd0, 10'd0), 1, 1,
                       pack4(10'd767, 10'd0, 10'd0, 10'd0), 1, 8'hFF));
        send(load_item(1, 1, 2, pack4(ka, kb, 10'd0, 10'd0), 1, 4,
                       pack4(10'd1023, 10'd0, 10'd17, 10'd500), 0, 8'h00));
        send(load_item(2, 1, 1, pack4(kc, 10'd0, 10'd0, 10'd0), 1, 0, 40'd0, 1, 8'h00));
        send(load_item(3, 1, 1, pack4(kd, 10'd0, 10'd0, 10'd0), 1, 7,
                       pack4(10'd1, 10'd2, 10'd3, 10'd4), 0, 8'h5A));
        send(load_item(14, 1, 0, 40'd0, 1, 1, pack4(10'd5, 10'd0, 10'd0, 10'd0), 1, 8'h11));
        send(load_item(15, 1, 7, pack4(ka, kb, kc, kd), 1, 1,
                       pack4(10'd6, 10'd0, 10'd0, 10'd0), 1, 8'h22));
        send(key_item(kcr_pkg::EVK_PRESS, ka));
        send(key_item(kcr_pkg::EVK_REPEAT, ka));
        send(key_item(kcr_pkg::EVK_PRESS, kb));
        send(key_item(kcr_pkg::EVK_REPEAT, kb));
        send(key_item(kcr_pkg::EVK_RELEASE, kb));
        send(key_item(kcr_pkg::EVK_RELEASE, ka));
        send(key_item(kcr_pkg::EVK_PRESS, kc));
        send(key_item(kcr_pkg::EVK_REPEAT, kc));
        send(key_item(kcr_pkg::EVK_RELEASE, kc));
        send(key_item(kcr_pkg::EVK_PRESS, kd));
        send(key_item(kcr_pkg::EVK_RELEASE, kd));
        send(key_item(EVK_UNUSED, ka));
        send(key_item(kcr_pkg::EVK_PRESS, 10'd1023));
        send(key_item(kcr_pkg::EVK_RELEASE, 10'd1023));
        // One press past a full held list is not recorded.
        for (int i = 0; i <= kcr_pkg::MAX_HELD; i++)
            send(key_item(kcr_pkg::EVK_PRESS, 10'(200 + i)));
        send(key_item(kcr_pkg::EVK_RELEASE, 10'd200));
        drain();

        write_config(0, 1, 1);
        random_phase(75);
        drain();

        // The output side holds off while words keep coming, so the input backs up.
        write_config(1, 0, 1);
        long_hold = 400;
        random_phase(75);
        drain();

        write_config(0, 0, 0);
        random_phase(35);
        in_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        random_phase(35);
        drain();

        write_config(1, 1, 0);
        random_phase(25);
        drain();
        write_config(0, 1, 1);
        tx_gaps = 0;
        rx_stalls = 0;
        random_phase(50);
        drain();

        if (sb.pending_results.size() != 0) sb.errors++;
        $display("Run covered %0d key events and %0d table loads, %0d result words checked.",
                 sb.key_items, sb.load_items, sb.checked);
        $display("Settings visited: forwarding, sink, sync on and off, with stalls and backlog.");
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
